// ----- rtl/dsp_pkg.sv -----
`default_nettype none
package dsp_pkg;

   localparam int MAX_NODE_COUNT_DEF = 16;
   localparam int ADDR_NODES = 16;

   localparam int DIST_W = 24;
   localparam int WEIGHT_W = 16;
   localparam int NODE_W = 4;
   localparam int CFG_W = 5;
   localparam int CSR_IDX_W = 1;

   localparam logic [DIST_W-1:0] DIST_INF = 24'hFFFFFF;
   localparam logic [WEIGHT_W-1:0] NO_EDGE = 16'hFFFF;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_RUN = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_NODE = 1'd1;

   localparam logic [CFG_W-1:0] NODE_COUNT_RST = 5'd4;
   localparam logic [NODE_W-1:0] SOURCE_NODE_RST = 4'd0;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_INIT_RD = 7'b0000010,
      ST_INIT_WR = 7'b0000100,
      ST_MIN     = 7'b0001000,
      ST_RLX_RD  = 7'b0010000,
      ST_RLX_WR  = 7'b0100000,
      ST_OUT     = 7'b1000000
   } state_type;

   typedef struct packed {
      logic [DIST_W-1:0]   base;
      logic [WEIGHT_W-1:0] weight;
      logic [DIST_W-1:0]   bound;
   } alu_op_type;

   typedef struct packed {
      logic [DIST_W-1:0] cand;
      logic              less;
   } alu_res_type;

endpackage
`default_nettype wire

// ----- rtl/dsp_ram.sv -----
`default_nettype none
module dsp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- rtl/dsp_alu.sv -----
`default_nettype none
module dsp_alu
   import dsp_pkg::*;
(
   input  wire alu_op_type  op,
   output alu_res_type      res
);

   logic [DIST_W-1:0] edge_d;
   logic [DIST_W:0]   sum;
   logic [DIST_W-1:0] cand;

   always_comb begin
      edge_d = (op.weight == NO_EDGE) ? DIST_INF : DIST_W'(op.weight);
      sum = {1'b0, op.base} + {1'b0, edge_d};
      if (op.base == DIST_INF || edge_d == DIST_INF || sum >= {1'b0, DIST_INF}) begin
         cand = DIST_INF;
      end else begin
         cand = sum[DIST_W-1:0];
      end
      res.cand = cand;
      res.less = (cand < op.bound);
   end

endmodule
`default_nettype wire

// ----- rtl/dijkstra_shortest_path.sv -----
//  channel | direction | handshake          | word
//  req     | in        | req_valid/req_stall | cmd, from_node, to_node, weight
//  rsp     | out       | rsp_valid/rsp_stall | node, dist_res, reachable, last
//  csr     | in        | csr_we              | csr_index, csr_wdata
//
//  Edge writes are accepted back to back while idle. A run over N nodes
//  sets N distances, does up to N-1 rounds of minimum search and
//  relaxation, and emits N result words; adjacency reads are registered
//  and a single shared add/compare unit does all sums. Reset clears the
//  sequencer and settled flags and loads config defaults; the matrix holds
//  garbage until written. rsp_stall holds the result word and the sequencer.
`default_nettype none
module dijkstra_shortest_path
   import dsp_pkg::*;
#(
   parameter int MAX_NODE_COUNT = MAX_NODE_COUNT_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_cmd,
   input  wire logic [NODE_W-1:0]    req_from_node,
   input  wire logic [NODE_W-1:0]    req_to_node,
   input  wire logic [WEIGHT_W-1:0]  req_weight,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [NODE_W-1:0]         rsp_node,
   output logic [DIST_W-1:0]         rsp_dist_res,
   output logic                      rsp_reachable,
   output logic                      rsp_last,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wdata
);

   localparam int NODES = (MAX_NODE_COUNT < ADDR_NODES) ? MAX_NODE_COUNT : ADDR_NODES;
   localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int NCW = NW + 1;
   localparam int RAM_DEPTH = 1 << (2 * NW);

   state_type state_ff, state_in;

   logic [CFG_W-1:0]  node_count_ff, node_count_in;
   logic [NODE_W-1:0] source_ff, source_in;

   logic [NCW-1:0] n_ff, n_in;
   logic [NCW-1:0] round_ff, round_in;
   logic [NW-1:0]  idx_ff, idx_in;
   logic [NW-1:0]  pick_ff, pick_in;
   logic [DIST_W-1:0] min_d_ff, min_d_in;
   logic found_ff, found_in;
   logic src_bad_ff, src_bad_in;
   logic [NODES-1:0] settled_ff, settled_in;
   logic [DIST_W-1:0] best_ff [NODES];
   logic best_we;
   logic [DIST_W-1:0] best_wdata;

   logic rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0] rsp_node_ff, rsp_node_in;
   logic [DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic rsp_last_ff, rsp_last_in;

   logic req_accept;
   logic idx_last;
   logic slot_free;
   logic take;
   logic [NCW-1:0] n_eff;
   logic [NW-1:0] src_idx;
   logic [DIST_W-1:0] best_rd;

   logic ram_we;
   logic [2*NW-1:0] ram_waddr, ram_raddr;
   logic [WEIGHT_W-1:0] ram_rdata;

   alu_op_type  alu_op;
   alu_res_type alu_res;

   dsp_ram #(
      .WIDTH(WEIGHT_W),
      .DEPTH(RAM_DEPTH)
   ) u_matrix (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(req_weight),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   dsp_alu u_alu (
      .op (alu_op),
      .res(alu_res)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign idx_last = ({1'b0, idx_ff} == (n_ff - NCW'(1)));
   assign src_idx = source_ff[NW-1:0];
   assign best_rd = best_ff[idx_ff];

   assign ram_we = req_accept && (req_cmd == CMD_WRITE)
                   && (7'(req_from_node) < 7'(MAX_NODE_COUNT))
                   && (7'(req_to_node) < 7'(MAX_NODE_COUNT));
   assign ram_waddr = {req_from_node[NW-1:0], req_to_node[NW-1:0]};
   assign ram_raddr = (state_ff == ST_INIT_RD) ? {src_idx, idx_ff} : {pick_ff, idx_ff};

   always_comb begin
      if (node_count_ff == '0) begin
         n_eff = NCW'(1);
      end else if (node_count_ff > CFG_W'(NODES)) begin
         n_eff = NCW'(NODES);
      end else begin
         n_eff = NCW'(node_count_ff);
      end
   end

   always_comb begin
      case (state_ff)
         ST_INIT_WR: begin
            alu_op.base = '0;
            alu_op.weight = ram_rdata;
            alu_op.bound = DIST_INF;
         end
         ST_RLX_WR: begin
            alu_op.base = min_d_ff;
            alu_op.weight = ram_rdata;
            alu_op.bound = best_rd;
         end
         default: begin
            alu_op.base = best_rd;
            alu_op.weight = '0;
            alu_op.bound = min_d_ff;
         end
      endcase
   end

   assign take = !settled_ff[idx_ff] && alu_res.less;

   always_comb begin
      node_count_in = node_count_ff;
      source_in = source_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_NODE_COUNT:  node_count_in = csr_wdata;
            CSR_SOURCE_NODE: source_in = csr_wdata[NODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      n_in = n_ff;
      round_in = round_ff;
      idx_in = idx_ff;
      pick_in = pick_ff;
      min_d_in = min_d_ff;
      found_in = found_ff;
      src_bad_in = src_bad_ff;
      settled_in = settled_ff;
      best_we = 1'b0;
      best_wdata = alu_res.cand;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_node_in = rsp_node_ff;
      rsp_dist_in = rsp_dist_ff;
      rsp_last_in = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_cmd == CMD_RUN) begin
               n_in = n_eff;
               idx_in = '0;
               settled_in = '0;
               src_bad_in = (5'(source_ff) >= 5'(n_eff));
               if (5'(source_ff) >= 5'(n_eff)) begin
                  state_in = ST_OUT;
               end else begin
                  settled_in[src_idx] = 1'b1;
                  state_in = ST_INIT_RD;
               end
            end
         end
         ST_INIT_RD: begin
            state_in = ST_INIT_WR;
         end
         ST_INIT_WR: begin
            best_we = 1'b1;
            if (idx_ff == src_idx) begin
               best_wdata = '0;
            end
            round_in = NCW'(1);
            min_d_in = DIST_INF;
            found_in = 1'b0;
            if (idx_last) begin
               idx_in = '0;
               state_in = (n_ff > NCW'(1)) ? ST_MIN : ST_OUT;
            end else begin
               idx_in = idx_ff + NW'(1);
               state_in = ST_INIT_RD;
            end
         end
         ST_MIN: begin
            if (take) begin
               min_d_in = best_rd;
               pick_in = idx_ff;
               found_in = 1'b1;
            end
            if (idx_last) begin
               idx_in = '0;
               if (found_ff || take) begin
                  settled_in[take ? idx_ff : pick_ff] = 1'b1;
                  state_in = ST_RLX_RD;
               end else begin
                  state_in = ST_OUT;
               end
            end else begin
               idx_in = idx_ff + NW'(1);
            end
         end
         ST_RLX_RD: begin
            state_in = ST_RLX_WR;
         end
         ST_RLX_WR: begin
            best_we = take;
            if (idx_last) begin
               idx_in = '0;
               round_in = round_ff + NCW'(1);
               min_d_in = DIST_INF;
               found_in = 1'b0;
               state_in = ((round_ff + NCW'(1)) < n_ff) ? ST_MIN : ST_OUT;
            end else begin
               idx_in = idx_ff + NW'(1);
               state_in = ST_RLX_RD;
            end
         end
         ST_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_node_in = NODE_W'(idx_ff);
               rsp_dist_in = src_bad_ff ? DIST_INF : best_rd;
               rsp_last_in = idx_last;
               if (idx_last) begin
                  idx_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + NW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         node_count_ff <= NODE_COUNT_RST;
         source_ff <= SOURCE_NODE_RST;
         settled_ff <= '0;
         rsp_valid_ff <= 1'b0;
         n_ff <= NCW'(1);
         round_ff <= '0;
         idx_ff <= '0;
         found_ff <= 1'b0;
         src_bad_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         node_count_ff <= node_count_in;
         source_ff <= source_in;
         settled_ff <= settled_in;
         rsp_valid_ff <= rsp_valid_in;
         n_ff <= n_in;
         round_ff <= round_in;
         idx_ff <= idx_in;
         found_ff <= found_in;
         src_bad_ff <= src_bad_in;
      end
   end

   always_ff @(posedge clock) begin
      pick_ff <= pick_in;
      min_d_ff <= min_d_in;
      rsp_node_ff <= rsp_node_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_last_ff <= rsp_last_in;
      if (best_we) begin
         best_ff[idx_ff] <= best_wdata;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_node = rsp_node_ff;
   assign rsp_dist_res = rsp_dist_ff;
   assign rsp_reachable = (rsp_dist_ff != DIST_INF);
   assign rsp_last = rsp_last_ff;

   a_relax_pick_settled: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RLX_WR) |-> settled_ff[pick_ff])
      else $error("relax step on an unsettled pivot");

   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MIN) |-> (round_ff < n_ff))
      else $error("minimum search past the last round");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> ({1'b0, idx_ff} < n_ff))
      else $error("node index beyond node count");

   a_source_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && slot_free && !src_bad_ff && idx_ff == src_idx)
      |=> (rsp_dist_res == '0 && rsp_reachable))
      else $error("source not reported at distance zero");

endmodule
`default_nettype wire
